### sv/ttce_pkg.sv
// Shared types and constants for the text terminal cursor engine.
// Holds the command codes, character codes, cell helpers and the
// controller/datapath command and status structs. No dependencies.
package ttce_pkg;

  // Default screen geometry.
  localparam int DefColumns = 80;
  localparam int DefRows    = 25;

  // Field widths.
  localparam int CoordW   = 8;
  localparam int RowOutW  = 5;
  localparam int ColOutW  = 7;
  localparam int ByteW    = 8;
  localparam int CellW    = 16;
  localparam int KindW    = 3;
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  // Register index of the text color register (word address bit).
  localparam logic RegTextColor = 1'b0;

  // Command codes of an input item.
  typedef enum logic [KindW-1:0] {
    KindPut       = 3'd0,
    KindRead      = 3'd1,
    KindSetCursor = 3'd2,
    KindWriteCell = 3'd3,
    KindClear     = 3'd4
  } ttce_kind_e;

  // Character codes with special handling.
  localparam logic [ByteW-1:0] ChBackspace = 8'h08;
  localparam logic [ByteW-1:0] ChTab       = 8'h09;
  localparam logic [ByteW-1:0] ChNewline   = 8'h0A;
  localparam logic [ByteW-1:0] ChReturn    = 8'h0D;
  localparam logic [ByteW-1:0] ChSpace     = 8'h20;

  // Attribute used for the screen after reset and as reset of text_color.
  localparam logic [ByteW-1:0] ResetAttr = 8'h0F;

  // Tab stops lie on multiples of this.
  localparam int TabStep = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // capture a new input beat
    logic exec;        // decode and execute the captured item
    logic rd_capture;  // take the registered memory read data as result
    logic sweep_step;  // advance the cell sweep by one cell
    logic init_mode;   // sweep is the reset clearing pass
  } ttce_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_sweep;  // item scrolls or clears the screen
    logic need_read;   // item reads a cell in range
    logic sweep_last;  // sweep counter is at the last cell
  } ttce_stat_t;

  // A cell is the attribute byte over the character byte.
  function automatic logic [CellW-1:0] make_cell(logic [ByteW-1:0] ch,
                                                 logic [ByteW-1:0] attr);
    return {attr, ch};
  endfunction

endpackage

### sv/ttce_ctrl.sv
// Controller state machine of the text terminal cursor engine.
// Sequences capture, execution, memory sweeps and the result strobe.
// Depends on ttce_pkg for the command and status structs.
module ttce_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  ttce_pkg::ttce_stat_t stat_i,
  output ttce_pkg::ttce_cmd_t  cmd_o,
  output logic                 busy_o,
  output logic                 result_valid_o
);
  import ttce_pkg::*;

  localparam logic [2:0] StInit   = 3'd0;
  localparam logic [2:0] StIdle   = 3'd1;
  localparam logic [2:0] StExec   = 3'd2;
  localparam logic [2:0] StSweep  = 3'd3;
  localparam logic [2:0] StRdWait = 3'd4;
  localparam logic [2:0] StDone   = 3'd5;

  logic [2:0] state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StInit: begin
        cmd_o.sweep_step = 1'b1;
        cmd_o.init_mode  = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StExec;
        end
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        if (stat_i.need_sweep) begin
          state_d = StSweep;
        end else if (stat_i.need_read) begin
          state_d = StRdWait;
        end else begin
          state_d = StDone;
        end
      end
      StSweep: begin
        cmd_o.sweep_step = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = StDone;
        end
      end
      StRdWait: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = StDone;
      end
      StDone: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State register; the clearing pass runs first after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o         = (state_q != StIdle);
  assign result_valid_o = (state_q == StDone);

`ifndef SYNTH
  // A result beat lasts exactly one cycle.
  a_result_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held longer than one cycle");

  // A sweep only ends at the last cell.
  a_sweep_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSweep && !stat_i.sweep_last) |=> (state_q == StSweep))
    else $error("sweep left before the last cell");

  // An accepted beat is executed in the following cycle.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == StExec && cmd_o.exec))
    else $error("accepted item not executed next");
`endif

endmodule

### sv/ttce_datapath.sv
// Datapath of the text terminal cursor engine: cursor registers, the
// screen memory with its write stage, the sweep counter and result registers.
// Depends on ttce_pkg for constants, the cell helper and the structs.
module ttce_datapath #(
  parameter int COLUMNS = ttce_pkg::DefColumns,
  parameter int ROWS    = ttce_pkg::DefRows
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ttce_pkg::ttce_cmd_t                cmd_i,
  output ttce_pkg::ttce_stat_t               stat_o,
  input  logic [ttce_pkg::ByteW-1:0]         text_color_i,
  input  logic [ttce_pkg::KindW-1:0]         kind_i,
  input  logic [ttce_pkg::ByteW-1:0]         char_code_i,
  input  logic [ttce_pkg::CoordW-1:0]        row_i,
  input  logic [ttce_pkg::CoordW-1:0]        column_i,
  input  logic [ttce_pkg::ByteW-1:0]         cell_color_i,
  output logic [ttce_pkg::RowOutW-1:0]       cursor_row_o,
  output logic [ttce_pkg::ColOutW-1:0]       cursor_col_o,
  output logic [ttce_pkg::CellW-1:0]         cell_value_o,
  output logic                               wrote_cell_o,
  output logic                               scrolled_o
);
  import ttce_pkg::*;

  localparam int Cells = ROWS * COLUMNS;
  localparam int AddrW = $clog2(Cells);
  localparam logic [AddrW-1:0]  LastAddr  = AddrW'(Cells - 1);
  localparam logic [AddrW-1:0]  CopyCells = AddrW'(Cells - COLUMNS);
  localparam logic [AddrW-1:0]  ColsA     = AddrW'(COLUMNS);
  localparam logic [CoordW:0]   ColLimit  = (CoordW + 1)'(COLUMNS);
  localparam logic [CoordW:0]   RowLimit  = (CoordW + 1)'(ROWS);
  localparam logic [CoordW-1:0] LastCol   = CoordW'(COLUMNS - 1);
  localparam logic [CoordW-1:0] LastRow   = CoordW'(ROWS - 1);
  localparam logic [CoordW:0]   TabAdd    = (CoordW + 1)'(TabStep);
  localparam logic [CoordW:0]   TabMask   = ~((CoordW + 1)'(TabStep - 1));

  // Captured item.
  logic [KindW-1:0]  kind_q, kind_d;
  logic [ByteW-1:0]  ch_q, ch_d;
  logic [CoordW-1:0] row_q, row_d;
  logic [CoordW-1:0] col_q, col_d;
  logic [ByteW-1:0]  color_q, color_d;

  // Cursor and result registers.
  logic [CoordW-1:0] cur_row_q, cur_row_d;
  logic [CoordW-1:0] cur_col_q, cur_col_d;
  logic [CellW-1:0]  cell_q, cell_d;
  logic              wrote_q, wrote_d;
  logic              scrolled_q, scrolled_d;

  // Sweep control.
  logic              scroll_mode_q, scroll_mode_d;
  logic [AddrW-1:0]  cnt_q, cnt_d;
  logic              copy;

  // Write stage and memory read port.
  logic              wr_en_q, wr_en_d;
  logic [AddrW-1:0]  wr_addr_q, wr_addr_d;
  logic              wr_copy_q, wr_copy_d;
  logic [CellW-1:0]  wr_data_q, wr_data_d;
  logic              rd_en;
  logic [AddrW-1:0]  rd_addr;
  logic [CellW-1:0]  rdata_q;
  logic [CellW-1:0]  screen_mem_q [Cells];

  // Put-character cursor movement.
  logic [CoordW:0]   pc_row, pc_col;
  logic              pc_print, pc_scroll;

  // Addresses and range check.
  logic [AddrW-1:0]  cur_addr, tgt_addr;
  logic              tgt_row_ok, tgt_col_ok, tgt_inside;

  // Cursor movement of a put-character item, including wrap and scroll.
  always_comb begin
    pc_row    = {1'b0, cur_row_q};
    pc_col    = {1'b0, cur_col_q};
    pc_print  = 1'b0;
    pc_scroll = 1'b0;
    case (ch_q)
      ChNewline: begin
        pc_col = '0;
        pc_row = pc_row + 1'b1;
      end
      ChReturn: begin
        pc_col = '0;
      end
      ChTab: begin
        pc_col = (pc_col + TabAdd) & TabMask;
      end
      ChBackspace: begin
        if (pc_col != '0) begin
          pc_col = pc_col - 1'b1;
        end else if (pc_row != '0) begin
          pc_row = pc_row - 1'b1;
          pc_col = {1'b0, LastCol};
        end
      end
      default: begin
        if (ch_q >= ChSpace) begin
          pc_print = 1'b1;
          pc_col   = pc_col + 1'b1;
        end
      end
    endcase
    if (pc_col >= ColLimit) begin
      pc_col = '0;
      pc_row = pc_row + 1'b1;
    end
    if (pc_row >= RowLimit) begin
      pc_scroll = 1'b1;
      pc_row    = {1'b0, LastRow};
    end
  end

  // Linear cell addresses of the cursor and of the item's target.
  assign cur_addr   = AddrW'(cur_row_q) * ColsA + AddrW'(cur_col_q);
  assign tgt_addr   = AddrW'(row_q) * ColsA + AddrW'(col_q);
  assign tgt_row_ok = ({1'b0, row_q} < RowLimit);
  assign tgt_col_ok = ({1'b0, col_q} < ColLimit);
  assign tgt_inside = tgt_row_ok && tgt_col_ok;

  // During a scroll the first cells copy from one row below.
  assign copy = cmd_i.sweep_step && !cmd_i.init_mode && scroll_mode_q
                && (cnt_q < CopyCells);

  // Item capture, execution and sweep sequencing.
  always_comb begin
    kind_d        = kind_q;
    ch_d          = ch_q;
    row_d         = row_q;
    col_d         = col_q;
    color_d       = color_q;
    cur_row_d     = cur_row_q;
    cur_col_d     = cur_col_q;
    cell_d        = cell_q;
    wrote_d       = wrote_q;
    scrolled_d    = scrolled_q;
    scroll_mode_d = scroll_mode_q;
    cnt_d         = cnt_q;
    wr_en_d       = 1'b0;
    wr_addr_d     = wr_addr_q;
    wr_copy_d     = 1'b0;
    wr_data_d     = wr_data_q;
    rd_en         = 1'b0;
    rd_addr       = tgt_addr;

    if (cmd_i.accept) begin
      kind_d  = kind_i;
      ch_d    = char_code_i;
      row_d   = row_i;
      col_d   = column_i;
      color_d = cell_color_i;
    end

    if (cmd_i.exec) begin
      cell_d        = '0;
      wrote_d       = 1'b0;
      scrolled_d    = 1'b0;
      scroll_mode_d = (kind_q == KindPut);
      cnt_d         = '0;
      unique case (kind_q)
        KindPut: begin
          cur_row_d  = pc_row[CoordW-1:0];
          cur_col_d  = pc_col[CoordW-1:0];
          scrolled_d = pc_scroll;
          if (pc_print) begin
            wr_en_d   = 1'b1;
            wr_addr_d = cur_addr;
            wr_data_d = make_cell(ch_q, text_color_i);
            cell_d    = make_cell(ch_q, text_color_i);
            wrote_d   = 1'b1;
          end
        end
        KindRead: begin
          rd_en = tgt_inside;
        end
        KindSetCursor: begin
          if (tgt_row_ok) begin
            cur_row_d = row_q;
          end
          if (tgt_col_ok) begin
            cur_col_d = col_q;
          end
        end
        KindWriteCell: begin
          if (tgt_inside) begin
            wr_en_d   = 1'b1;
            wr_addr_d = tgt_addr;
            wr_data_d = make_cell(ch_q, color_q);
            cell_d    = make_cell(ch_q, color_q);
            wrote_d   = 1'b1;
          end
        end
        KindClear: begin
          cur_row_d = '0;
          cur_col_d = '0;
          wrote_d   = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.rd_capture) begin
      cell_d = rdata_q;
    end

    // One cell per cycle: read the source a row below, write one stage later.
    if (cmd_i.sweep_step) begin
      rd_en     = copy;
      rd_addr   = cnt_q + ColsA;
      wr_en_d   = 1'b1;
      wr_addr_d = cnt_q;
      wr_copy_d = copy;
      wr_data_d = cmd_i.init_mode ? make_cell(ChSpace, ResetAttr)
                                  : make_cell(ChSpace, text_color_i);
      cnt_d     = cnt_q + 1'b1;
    end
  end

  assign stat_o.need_sweep = ((kind_q == KindPut) && pc_scroll) || (kind_q == KindClear);
  assign stat_o.need_read  = (kind_q == KindRead) && tgt_inside;
  assign stat_o.sweep_last = (cnt_q == LastAddr);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q     <= '0;
      cur_col_q     <= '0;
      scroll_mode_q <= 1'b0;
      cnt_q         <= '0;
      wr_en_q       <= 1'b0;
    end else begin
      cur_row_q     <= cur_row_d;
      cur_col_q     <= cur_col_d;
      scroll_mode_q <= scroll_mode_d;
      cnt_q         <= cnt_d;
      wr_en_q       <= wr_en_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    ch_q       <= ch_d;
    row_q      <= row_d;
    col_q      <= col_d;
    color_q    <= color_d;
    cell_q     <= cell_d;
    wrote_q    <= wrote_d;
    scrolled_q <= scrolled_d;
    wr_addr_q  <= wr_addr_d;
    wr_copy_q  <= wr_copy_d;
    wr_data_q  <= wr_data_d;
  end

  // Screen memory: one write port fed by the write stage, one registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_q) begin
      screen_mem_q[wr_addr_q] <= wr_copy_q ? rdata_q : wr_data_q;
    end
    if (rd_en) begin
      rdata_q <= screen_mem_q[rd_addr];
    end
  end

  assign cursor_row_o = cur_row_q[RowOutW-1:0];
  assign cursor_col_o = cur_col_q[ColOutW-1:0];
  assign cell_value_o = cell_q;
  assign wrote_cell_o = wrote_q;
  assign scrolled_o   = scrolled_q;

`ifndef SYNTH
  // Every memory write lands inside the screen.
  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_q |-> (wr_addr_q <= LastAddr))
    else $error("screen write outside the memory");

  // The cursor never leaves the screen.
  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cur_row_q} < RowLimit) && ({1'b0, cur_col_q} < ColLimit))
    else $error("cursor outside the screen");

  // A scroll copy reads a cell that has not yet been overwritten.
  a_copy_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    copy |-> (rd_addr <= LastAddr && rd_addr > cnt_q))
    else $error("scroll copy reads a stale or missing cell");
`endif

endmodule

### sv/text_terminal_cursor_engine.sv
// A result beat follows each item through the states exec and done; a read
// of a cell on the screen adds a read wait, and a scroll or a clear adds a
// sweep of the screen memory, one cell per cycle through its single write port.
// A new item is taken only when the previous one is done; busy is high meanwhile.
// Reset: cursor to the top left, text_color to 0x0F, then a clearing pass fills
// all ROWS*COLUMNS cells (2000 by default) with blanks, busy high.
module text_terminal_cursor_engine #(
  parameter int COLUMNS = ttce_pkg::DefColumns,
  parameter int ROWS    = ttce_pkg::DefRows
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ttce_pkg::ApbAddrW-1:0]    paddr,
  input  logic [ttce_pkg::ApbDataW-1:0]    pwdata,
  output logic [ttce_pkg::ApbDataW-1:0]    prdata,
  output logic                             pready,
  // Command beat.
  input  logic                             start,
  output logic                             busy,
  input  logic [ttce_pkg::KindW-1:0]       kind_i,
  input  logic [ttce_pkg::ByteW-1:0]       char_code_i,
  input  logic [ttce_pkg::CoordW-1:0]      row_i,
  input  logic [ttce_pkg::CoordW-1:0]      column_i,
  input  logic [ttce_pkg::ByteW-1:0]       cell_color_i,
  // Result beat.
  output logic                             result_valid_o,
  output logic [ttce_pkg::RowOutW-1:0]     cursor_row_out_o,
  output logic [ttce_pkg::ColOutW-1:0]     cursor_col_out_o,
  output logic [ttce_pkg::CellW-1:0]       cell_value_o,
  output logic                             wrote_cell_o,
  output logic                             scrolled_o
);
  import ttce_pkg::*;

  logic [ByteW-1:0] text_color_q, text_color_d;
  logic             reg_sel;
  ttce_cmd_t        cmd;
  ttce_stat_t       stat;

  // Register decode: bit 2 of the byte address selects the word.
  assign reg_sel = (paddr[2] == RegTextColor);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? ApbDataW'(text_color_q) : '0;

  always_comb begin
    text_color_d = text_color_q;
    if (psel && penable && pwrite && pready && reg_sel) begin
      text_color_d = pwdata[ByteW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= ResetAttr;
    end else begin
      text_color_q <= text_color_d;
    end
  end

  // Controller.
  ttce_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .stat_i         (stat),
    .cmd_o          (cmd),
    .busy_o         (busy),
    .result_valid_o (result_valid_o)
  );

  // Datapath.
  ttce_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .text_color_i (text_color_q),
    .kind_i       (kind_i),
    .char_code_i  (char_code_i),
    .row_i        (row_i),
    .column_i     (column_i),
    .cell_color_i (cell_color_i),
    .cursor_row_o (cursor_row_out_o),
    .cursor_col_o (cursor_col_out_o),
    .cell_value_o (cell_value_o),
    .wrote_cell_o (wrote_cell_o),
    .scrolled_o   (scrolled_o)
  );

endmodule
